FILE: design/ps2di_pkg.sv
// Package: shared types and constants for the PS/2 device identifier.
`default_nettype none
package ps2di_pkg;

  // Request kinds carried in the opcode field
  localparam logic OpByte    = 1'b0;
  localparam logic OpTimeout = 1'b1;

  // Reset reply bytes
  localparam logic [7:0] ByteSelfTest = 8'hAA;
  localparam logic [7:0] ByteAck      = 8'hFA;

  // Device type codes
  localparam logic [3:0] DevDisabled  = 4'd0;
  localparam logic [3:0] DevAtKbd     = 4'd1;
  localparam logic [3:0] DevMouse     = 4'd2;
  localparam logic [3:0] DevMouseScr  = 4'd3;
  localparam logic [3:0] DevMouse5Btn = 4'd4;
  localparam logic [3:0] DevMf2       = 4'd5;
  localparam logic [3:0] DevShort     = 4'd6;
  localparam logic [3:0] DevN97       = 4'd7;
  localparam logic [3:0] Dev122Key    = 4'd8;
  localparam logic [3:0] DevJpG       = 4'd9;
  localparam logic [3:0] DevJpP       = 4'd10;
  localparam logic [3:0] DevJpA       = 4'd11;
  localparam logic [3:0] DevSun       = 4'd12;

  typedef enum logic [1:0] {
    PhReply0 = 2'd0,
    PhReply1 = 2'd1,
    PhId0    = 2'd2,
    PhId1    = 2'd3
  } phase_e;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] held_reply;
    logic [7:0] held_id;
  } ps2di_state_t;

  typedef struct packed {
    logic       emit;
    logic [3:0] dev;
  } ps2di_res_t;

endpackage
`default_nettype wire

FILE: design/ps2di_if.sv
// Interfaces: request and result channels of the PS/2 device identifier.
`default_nettype none
interface ps2di_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface ps2di_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] device_type;

  modport source (output valid, output device_type, input ready);
  modport sink   (input valid, input device_type, output ready);
endinterface
`default_nettype wire

FILE: design/ps2_device_identifier.sv
// Top level: PS/2 device identifier, classifies a device from its reset reply.
// Path: a request is accepted into the request register; when it advances, its
// result, if it produces one, is loaded into the result register.
// Throughput: one request per cycle unless the result stalls; request and result
// registers form a two-stage pipeline whose only loop is the phase/state update.
// Reset: phase returns to awaiting the first reply byte, held bytes clear,
// both pipeline registers come up empty.
`default_nettype none
module ps2_device_identifier
  import ps2di_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ps2di_req_if.sink    req_i,
  ps2di_res_if.source  res_o
);

  // Request stage outputs
  logic       rq_valid;
  logic       rq_opcode;
  logic [7:0] rq_byte;
  logic       advance;

  // Classifier state and result
  ps2di_state_t state_q, state_d;
  ps2di_res_t   cls_res;

  // Result register
  logic       out_valid_q;
  logic [3:0] dev_q;

  // A buffered request is processed when the result register can take
  // whatever it produces: empty, or its result is being taken now.
  assign advance = rq_valid && (!out_valid_q || res_o.ready);

  ps2di_req_stage u_req_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (req_i.valid),
    .opcode_i  (req_i.opcode),
    .rx_byte_i (req_i.rx_byte),
    .advance_i (advance),
    .ready_o   (req_i.ready),
    .valid_o   (rq_valid),
    .opcode_o  (rq_opcode),
    .rx_byte_o (rq_byte)
  );

  ps2di_classify u_classify (
    .state_i   (state_q),
    .opcode_i  (rq_opcode),
    .rx_byte_i (rq_byte),
    .state_o   (state_d),
    .res_o     (cls_res)
  );

  // Phase and held bytes update only when a request is consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PhReply0, held_reply: 8'h00, held_id: 8'h00};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: a request without a result just drains a taken result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= cls_res.emit;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && cls_res.emit) begin
      dev_q <= cls_res.dev;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.device_type = dev_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // Back-pressure on the request side only while a request is buffered.
  a_ready_only_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> rq_valid
  ) else $error("request side stalled with empty request register");

  // Leaving the reply phase for the ID phase needs a held self-test or ack byte.
  a_pair_gate: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (advance && state_q.phase == PhReply1 && state_d.phase == PhId0) |->
      (state_q.held_reply == ByteSelfTest || state_q.held_reply == ByteAck)
  ) else $error("ID phase entered without a valid reply pair");

  // A stalled result is never dropped or overwritten.
  a_result_held: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> (out_valid_q && $stable(dev_q))
  ) else $error("stalled result lost");

  // Every classification returns to the first reply phase.
  a_emit_resets_phase: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (advance && cls_res.emit) |=> (state_q.phase == PhReply0)
  ) else $error("result produced without returning to start");

endmodule
`default_nettype wire

FILE: design/ps2di_classify.sv
// Classifier: next state and result for one request against the current state.
`default_nettype none
module ps2di_classify
  import ps2di_pkg::*;
(
  input  ps2di_state_t state_i,
  input  logic         opcode_i,
  input  logic [7:0]   rx_byte_i,
  output ps2di_state_t state_o,
  output ps2di_res_t   res_o
);

  function automatic logic [3:0] kbd_lookup(input logic [15:0] word);
    logic [3:0] dev;
    case (word)
      16'hAB83, 16'hABC1: dev = DevMf2;
      16'hAB84:           dev = DevShort;
      16'hAB85:           dev = DevN97;
      16'hAB86, 16'hAAAA: dev = Dev122Key;
      16'hAB90:           dev = DevJpG;
      16'hAB91:           dev = DevJpP;
      16'hAB92:           dev = DevJpA;
      16'hACA1:           dev = DevSun;
      default:            dev = DevDisabled;
    endcase
    return dev;
  endfunction

  logic        is_timeout;
  logic        pair_ok;
  logic        swap;
  logic [15:0] id_word;
  logic [3:0]  id_dev;

  assign is_timeout = (opcode_i == OpTimeout);
  assign pair_ok = ((state_i.held_reply == ByteSelfTest) && (rx_byte_i == ByteAck)) ||
                   ((state_i.held_reply == ByteAck) && (rx_byte_i == ByteSelfTest));

  // A 0xAB/0xAC second byte goes to the high half; if both are prefixes,
  // the later one still goes high.
  assign swap    = (rx_byte_i == 8'hAB) || (rx_byte_i == 8'hAC);
  assign id_word = swap ? {rx_byte_i, state_i.held_id} : {state_i.held_id, rx_byte_i};

  always_comb begin
    if (rx_byte_i == 8'h00 && state_i.held_id == 8'h00) begin
      id_dev = DevMouse;
    end else if (rx_byte_i == 8'h00 && state_i.held_id == 8'h03) begin
      id_dev = DevMouseScr;
    end else if (rx_byte_i == 8'h00 && state_i.held_id == 8'h04) begin
      id_dev = DevMouse5Btn;
    end else begin
      id_dev = kbd_lookup(id_word);
    end
  end

  always_comb begin
    state_o   = state_i;
    res_o     = '{emit: 1'b0, dev: DevDisabled};
    case (state_i.phase)
      PhReply0: begin
        if (!is_timeout) begin
          state_o.held_reply = rx_byte_i;
          state_o.phase      = PhReply1;
        end
      end
      PhReply1: begin
        if (!is_timeout) begin
          if (pair_ok) begin
            state_o.phase = PhId0;
          end else begin
            state_o.phase = PhReply0;
            res_o.emit    = 1'b1;
          end
        end
      end
      PhId0: begin
        if (is_timeout) begin
          state_o.phase = PhReply0;
          res_o.emit    = 1'b1;
          res_o.dev     = DevAtKbd;
        end else begin
          state_o.held_id = rx_byte_i;
          state_o.phase   = PhId1;
        end
      end
      PhId1: begin
        if (!is_timeout) begin
          state_o.phase = PhReply0;
          res_o.emit    = 1'b1;
          res_o.dev     = id_dev;
        end
      end
      default: begin
        state_o.phase = PhReply0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/ps2di_device_identifier.sv
// Request stage: input register of the PS/2 device identifier.
`default_nettype none
module ps2di_req_stage
  import ps2di_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic       opcode_i,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       ready_o,
  output logic       valid_o,
  output logic       opcode_o,
  output logic [7:0] rx_byte_o
);

  logic       valid_q;
  logic       opcode_q;
  logic [7:0] rx_byte_q;

  // Slot is free when empty or when its request moves on this cycle.
  assign ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      opcode_q  <= opcode_i;
      rx_byte_q <= rx_byte_i;
    end
  end

  assign valid_o   = valid_q;
  assign opcode_o  = opcode_q;
  assign rx_byte_o = rx_byte_q;

endmodule
`default_nettype wire
